>>> hdl/cca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cave cellular automaton package
// Shared constants for the cave map automaton: item kinds, register map,
// reset values and limits.
// ----------------------------------------------------------------------------
package cca_pkg;

    // Default store geometry
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int MIN_DIM        = 3;

    // Item kinds carried on the input tuser
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_RUN  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // Register indexes (byte address 4 * index)
    localparam logic [1:0] REG_GRID_WIDTH     = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_PASS_COUNT     = 2'd2;
    localparam logic [1:0] REG_WALL_THRESHOLD = 2'd3;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Reset values of the registers
    localparam logic [6:0] RST_GRID_WIDTH     = 7'd64;
    localparam logic [6:0] RST_GRID_HEIGHT    = 7'd64;
    localparam logic [7:0] RST_PASS_COUNT     = 8'd4;
    localparam logic [3:0] RST_WALL_THRESHOLD = 4'd5;

    // Cells in the 3x3 neighbourhood; also the last step of the cell sequence
    localparam logic [3:0] NB_CELLS = 4'd9;

    // Saturation value of the floor count
    localparam int FLOOR_MAX = 8191;

endpackage : cca_pkg
`default_nettype wire

>>> hdl/cave_cellular_automaton.sv
// Flow: loads, unused kinds and reads off the grid go from S_EXEC straight to S_OUT, reads
// inside the grid pass through S_RDWAIT first. A run makes P passes on a W x H grid, each
// sweeping the interior in S_PASS and copying the map to scratch in S_COPY, then counts
// floors in S_COUNT; each interior cell reads its neighbours on the single scratch read port.
// Throughput: one item at a time; the input is not ready until the result is registered.
// Reset (synchronous, active low) clears the sequencer and output valid, sets 64, 64, 4, 5.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cave map cellular automaton
// Holds a wall/floor map and a scratch copy, and runs 3x3 neighbourhood
// passes over them with one shared neighbour counter under a sequencer.
// ----------------------------------------------------------------------------
module cave_cellular_automaton #(
    parameter int MAX_WIDTH  = cca_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cca_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input stream
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [15:0]                     i_s_axis_tdata,  // cell_index, wall_bit, seed_wall
    input  wire logic [1:0]                      i_s_axis_tuser,  // kind
    // Output stream
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic      [15:0]                     o_m_axis_tdata,  // cell_wall, floor_count
    // Configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cca_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [cca_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [cca_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CELL_W = $clog2(DEPTH + 1);
    localparam int WD_W   = $clog2(MAX_WIDTH + 1);
    localparam int HT_W   = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EXEC   = 7'b0000010,
        S_RDWAIT = 7'b0000100,
        S_PASS   = 7'b0001000,
        S_COPY   = 7'b0010000,
        S_COUNT  = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [6:0] r_grid_width;
    logic [6:0] r_grid_height;
    logic [7:0] r_pass_count;
    logic [3:0] r_wall_threshold;

    // Captured item
    logic [1:0]  r_kind;
    logic [11:0] r_idx;
    logic        r_wall;
    logic        r_seed;

    // Sweep state
    logic [WD_W-1:0]   r_x;
    logic [HT_W-1:0]   r_y;
    logic [ADDR_W-1:0] r_tl;
    logic [ADDR_W-1:0] r_c;
    logic [ADDR_W-1:0] r_nb;
    logic [1:0]        r_dx;
    logic [3:0]        r_k;
    logic [3:0]        r_acc;
    logic [7:0]        r_p;
    logic [CELL_W-1:0] r_a;
    logic [ADDR_W-1:0] r_wa;
    logic              r_wv;
    logic [CELL_W-1:0] r_cnt;

    // Result staging and output register
    logic        r_res_wall;
    logic [12:0] r_res_floor;
    logic        r_out_valid;
    logic        r_out_wall;
    logic [12:0] r_out_floor;

    // Clamped geometry
    logic [WD_W-1:0]   w;
    logic [HT_W-1:0]   h;
    logic [CELL_W-1:0] cells;
    logic              idx_ok;

    // Memory ports
    logic              map_we;
    logic [ADDR_W-1:0] map_waddr;
    logic              map_wdata;
    logic [ADDR_W-1:0] map_raddr;
    logic              map_rdata;
    logic              scr_we;
    logic [ADDR_W-1:0] scr_waddr;
    logic              scr_wdata;
    logic [ADDR_W-1:0] scr_raddr;
    logic              scr_rdata;

    logic [3:0]        nb_sum;
    logic              wall_nx;
    logic              last_col;
    logic              last_row;
    logic [CELL_W-1:0] cnt_nx;
    logic [12:0]       floor_sat;
    logic              in_beat;
    logic              out_load;

    always_comb begin
        if (r_grid_width < 7'(cca_pkg::MIN_DIM)) begin
            w = WD_W'(cca_pkg::MIN_DIM);
        end else if (int'(r_grid_width) > MAX_WIDTH) begin
            w = WD_W'(MAX_WIDTH);
        end else begin
            w = WD_W'(r_grid_width);
        end
        if (r_grid_height < 7'(cca_pkg::MIN_DIM)) begin
            h = HT_W'(cca_pkg::MIN_DIM);
        end else if (int'(r_grid_height) > MAX_HEIGHT) begin
            h = HT_W'(MAX_HEIGHT);
        end else begin
            h = HT_W'(r_grid_height);
        end
    end

    assign cells  = CELL_W'(w) * CELL_W'(h);
    assign idx_ok = (int'(r_idx) < int'(cells));

    // Shared neighbour counter and threshold compare
    assign nb_sum   = r_acc + {3'b000, scr_rdata};
    assign wall_nx  = (nb_sum >= r_wall_threshold);
    assign last_col = (r_x == w - WD_W'(2));
    assign last_row = (r_y == h - HT_W'(2));

    assign cnt_nx    = r_cnt + CELL_W'(r_wv & ~map_rdata);
    assign floor_sat = (int'(cnt_nx) > cca_pkg::FLOOR_MAX) ? 13'(cca_pkg::FLOOR_MAX)
                                                           : 13'(cnt_nx);

    assign in_beat  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);

    // Memory port steering
    always_comb begin
        map_we    = 1'b0;
        map_waddr = r_c;
        map_wdata = wall_nx;
        map_raddr = ADDR_W'(r_a);
        scr_we    = 1'b0;
        scr_waddr = r_wa;
        scr_wdata = map_rdata;
        scr_raddr = r_nb;
        unique case (r_state)
            S_EXEC: begin
                map_raddr = ADDR_W'(r_idx);
                if (r_kind == cca_pkg::KIND_LOAD && idx_ok) begin
                    map_we    = 1'b1;
                    map_waddr = ADDR_W'(r_idx);
                    map_wdata = r_wall;
                    scr_we    = 1'b1;
                    scr_waddr = ADDR_W'(r_idx);
                    scr_wdata = r_wall | r_seed;
                end
            end
            S_PASS: begin
                map_we = (r_k == cca_pkg::NB_CELLS);
            end
            S_COPY: begin
                scr_we = r_wv;
            end
            default: begin
            end
        endcase
    end

    cca_ram #(
        .DATA_W (1),
        .DEPTH  (DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    cca_ram #(
        .DATA_W (1),
        .DEPTH  (DEPTH)
    ) u_scratch_ram (
        .i_clk   (i_clk),
        .i_we    (scr_we),
        .i_waddr (scr_waddr),
        .i_wdata (scr_wdata),
        .i_raddr (scr_raddr),
        .o_rdata (scr_rdata)
    );

    // Configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width     <= cca_pkg::RST_GRID_WIDTH;
            r_grid_height    <= cca_pkg::RST_GRID_HEIGHT;
            r_pass_count     <= cca_pkg::RST_PASS_COUNT;
            r_wall_threshold <= cca_pkg::RST_WALL_THRESHOLD;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                cca_pkg::REG_GRID_WIDTH:     r_grid_width     <= pwdata[6:0];
                cca_pkg::REG_GRID_HEIGHT:    r_grid_height    <= pwdata[6:0];
                cca_pkg::REG_PASS_COUNT:     r_pass_count     <= pwdata[7:0];
                cca_pkg::REG_WALL_THRESHOLD: r_wall_threshold <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            cca_pkg::REG_GRID_WIDTH:     prdata = 32'(r_grid_width);
            cca_pkg::REG_GRID_HEIGHT:    prdata = 32'(r_grid_height);
            cca_pkg::REG_PASS_COUNT:     prdata = 32'(r_pass_count);
            cca_pkg::REG_WALL_THRESHOLD: prdata = 32'(r_wall_threshold);
            default:                     prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res_wall  <= 1'b0;
                    r_res_floor <= '0;
                    if (r_kind == cca_pkg::KIND_RUN) begin
                        r_p   <= '0;
                        r_a   <= '0;
                        r_wv  <= 1'b0;
                        r_cnt <= '0;
                        r_x   <= WD_W'(1);
                        r_y   <= HT_W'(1);
                        r_tl  <= '0;
                        r_nb  <= '0;
                        r_c   <= ADDR_W'(w) + ADDR_W'(1);
                        r_k   <= '0;
                        r_dx  <= '0;
                        r_acc <= '0;
                        if (r_pass_count == 8'd0) begin
                            r_state <= S_COUNT;
                        end else begin
                            r_state <= S_PASS;
                        end
                    end else if (r_kind == cca_pkg::KIND_READ && idx_ok) begin
                        r_state <= S_RDWAIT;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_RDWAIT: begin
                    r_res_wall <= map_rdata;
                    r_state    <= S_OUT;
                end
                S_PASS: begin
                    // Reads are issued in steps 0..8 and each is summed in the following step.
                    if (r_k == cca_pkg::NB_CELLS) begin
                        r_k   <= '0;
                        r_dx  <= '0;
                        r_acc <= '0;
                        if (last_col) begin
                            // Top-left of the next row's first interior cell lies three on.
                            r_tl <= r_tl + ADDR_W'(3);
                            r_nb <= r_tl + ADDR_W'(3);
                            r_c  <= r_c + ADDR_W'(3);
                            r_x  <= WD_W'(1);
                            r_y  <= r_y + HT_W'(1);
                            if (last_row) begin
                                r_a     <= '0;
                                r_wv    <= 1'b0;
                                r_state <= S_COPY;
                            end
                        end else begin
                            r_tl <= r_tl + ADDR_W'(1);
                            r_nb <= r_tl + ADDR_W'(1);
                            r_c  <= r_c + ADDR_W'(1);
                            r_x  <= r_x + WD_W'(1);
                        end
                    end else begin
                        r_k <= r_k + 4'd1;
                        if (r_k != 4'd0) begin
                            r_acc <= nb_sum;
                        end
                        if (r_dx == 2'd2) begin
                            r_dx <= '0;
                            r_nb <= r_nb + ADDR_W'(w) - ADDR_W'(2);
                        end else begin
                            r_dx <= r_dx + 2'd1;
                            r_nb <= r_nb + ADDR_W'(1);
                        end
                    end
                end
                S_COPY: begin
                    if (r_a == cells) begin
                        r_a   <= '0;
                        r_wv  <= 1'b0;
                        // The sweep restarts at the first interior cell for the next pass.
                        r_x   <= WD_W'(1);
                        r_y   <= HT_W'(1);
                        r_tl  <= '0;
                        r_nb  <= '0;
                        r_c   <= ADDR_W'(w) + ADDR_W'(1);
                        r_k   <= '0;
                        r_dx  <= '0;
                        r_acc <= '0;
                        if (r_p == r_pass_count - 8'd1) begin
                            r_cnt   <= '0;
                            r_state <= S_COUNT;
                        end else begin
                            r_p     <= r_p + 8'd1;
                            r_state <= S_PASS;
                        end
                    end else begin
                        r_wa <= ADDR_W'(r_a);
                        r_a  <= r_a + CELL_W'(1);
                        r_wv <= 1'b1;
                    end
                end
                S_COUNT: begin
                    r_cnt <= cnt_nx;
                    if (r_a == cells) begin
                        r_res_floor <= floor_sat;
                        r_state     <= S_OUT;
                    end else begin
                        r_a  <= r_a + CELL_W'(1);
                        r_wv <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Item capture and output payload (no reset)
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_kind <= i_s_axis_tuser;
            r_idx  <= i_s_axis_tdata[11:0];
            r_wall <= i_s_axis_tdata[12];
            r_seed <= i_s_axis_tdata[13];
        end
        if (out_load) begin
            r_out_wall  <= r_res_wall;
            r_out_floor <= r_res_floor;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_floor, r_out_wall};

endmodule : cave_cellular_automaton
`default_nettype wire

>>> hdl/cca_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cca_ram #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule : cca_ram
`default_nettype wire

>>> hdl/cca_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cave cellular automaton port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module cca_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [15:0] o_m_axis_tdata
);

    // Nothing is offered on the output in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled result beat stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result beat changed");

    // The block is not ready again in the cycle after it takes an item.
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready straight after an accepted beat");

    // A result carries either a cell value or a floor count, never both, and no pad bits.
    a_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[0] && (o_m_axis_tdata[13:1] != 13'd0))
                            && (o_m_axis_tdata[15:14] == 2'b00))
        else $error("malformed result beat");

endmodule : cca_checker

bind cave_cellular_automaton cca_checker u_cca_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cave cellular automaton testbench
// Drives load, run and read beats into the automaton over its input stream,
// sets up the grid through the register port, and checks every result beat
// against a behavioural copy of the map, the scratch copy and the registers
// kept inside the bench. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import cca_pkg::*;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         STORE_DEPTH  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int         FILL_WIDTH   = 12;
    localparam int         FILL_CELLS   = FILL_WIDTH * MIN_DIM;
    localparam int         SAT_CELLS    = DEF_MAX_WIDTH * MIN_DIM;
    localparam int         RANDOM_ITEMS = 45;
    localparam int         IDLE_SETTLE  = 20;
    localparam int         LONG_HOLD    = 300;

    typedef struct packed {
        logic        cell_wall;
        logic [12:0] floor_count;
    } t_cave_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [15:0]           i_s_axis_tdata;   // cell_index, wall_bit, seed_wall
    logic [1:0]            i_s_axis_tuser;   // kind
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [15:0]           o_m_axis_tdata;   // cell_wall, floor_count
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Bench copy of the block's state
    bit          cave_map     [0:STORE_DEPTH-1];
    bit          cave_scratch [0:STORE_DEPTH-1];
    logic [6:0]  cfg_width;
    logic [6:0]  cfg_height;
    logic [7:0]  cfg_passes;
    logic [3:0]  cfg_threshold;

    t_cave_result pending_results[$];
    int           mismatch_count = 0;
    bit           source_idling  = 1'b1;
    bit           sink_idling    = 1'b1;
    bit           long_hold_req  = 1'b0;

    cave_cellular_automaton dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int clamp_dim(input int v, input int maxv);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int grid_cols();
        return clamp_dim(cfg_width, DEF_MAX_WIDTH);
    endfunction

    function automatic int grid_rows();
        return clamp_dim(cfg_height, DEF_MAX_HEIGHT);
    endfunction

    function automatic int used_cells();
        return grid_cols() * grid_rows();
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    endfunction

    function automatic logic [31:0] reg_value(input logic [1:0] idx);
        case (idx)
            REG_GRID_WIDTH:  return 32'(cfg_width);
            REG_GRID_HEIGHT: return 32'(cfg_height);
            REG_PASS_COUNT:  return 32'(cfg_passes);
            default:         return 32'(cfg_threshold);
        endcase
    endfunction

    // One automaton pass: the interior is rebuilt from the scratch copy, then
    // the used part of the map is copied back.
    function automatic void evolve_once(input int w, input int h);
        int walls;
        for (int y = 1; y + 1 < h; y++) begin
            for (int x = 1; x + 1 < w; x++) begin
                walls = 0;
                for (int dy = 0; dy < 3; dy++)
                    for (int dx = 0; dx < 3; dx++)
                        walls += cave_scratch[(y + dy - 1) * w + (x + dx - 1)];
                cave_map[y * w + x] = (walls >= cfg_threshold);
            end
        end
        for (int i = 0; i < w * h; i++)
            cave_scratch[i] = cave_map[i];
    endfunction

    function automatic t_cave_result predict_cave(input logic [1:0] kind, input logic [11:0] idx,
                                                  input logic wall, input logic seed);
        t_cave_result r;
        int           n;
        int           floors;
        r = '0;
        n = used_cells();
        case (kind)
            KIND_LOAD: begin
                if (idx < n) begin
                    cave_map[idx]     = wall;
                    cave_scratch[idx] = wall | seed;
                end
            end
            KIND_RUN: begin
                for (int p = 0; p < cfg_passes; p++)
                    evolve_once(grid_cols(), grid_rows());
                floors = 0;
                for (int i = 0; i < n; i++)
                    if (!cave_map[i]) floors++;
                if (floors > FLOOR_MAX) floors = FLOOR_MAX;
                r.floor_count = 13'(floors);
            end
            KIND_READ: begin
                if (idx < n) r.cell_wall = cave_map[idx];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Sends one beat and queues its expected result once it is accepted.
    task automatic send_item(input logic [1:0] kind, input logic [11:0] idx,
                             input logic wall, input logic seed);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= {2'b00, seed, wall, idx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(predict_cave(kind, idx, wall, seed));
        gap = source_idling ? gap_len() : 0;
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input logic [1:0] idx);
        logic [31:0] rdata;
        apb_access(1'b0, idx, '0, rdata);
        if (rdata !== reg_value(idx)) report_mismatch("register read-back", rdata, reg_value(idx));
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] unused;
        apb_access(1'b1, idx, value, unused);
        case (idx)
            REG_GRID_WIDTH:  cfg_width     = value[6:0];
            REG_GRID_HEIGHT: cfg_height    = value[6:0];
            REG_PASS_COUNT:  cfg_passes    = value[7:0];
            default:         cfg_threshold = value[3:0];
        endcase
        check_reg(idx);
    endtask

    task automatic set_config(input int w, input int h, input int passes, input int threshold);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_PASS_COUNT, passes);
        write_reg(REG_WALL_THRESHOLD, threshold);
    endtask

    task automatic load_random_grid();
        for (int i = 0; i < used_cells(); i++)
            send_item(KIND_LOAD, 12'(i), 1'($urandom), 1'($urandom));
    endtask

    // Result checker: each accepted result beat is matched with the oldest expectation.
    always @(posedge i_clk) begin
        t_cave_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat", o_m_axis_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata[0] !== want.cell_wall)
                    report_mismatch("cell_wall", o_m_axis_tdata[0], want.cell_wall);
                if (o_m_axis_tdata[13:1] !== want.floor_count)
                    report_mismatch("floor_count", o_m_axis_tdata[13:1], want.floor_count);
                if (o_m_axis_tdata[15:14] !== 2'b00)
                    report_mismatch("tdata padding", o_m_axis_tdata[15:14], 0);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when a test asks for it.
    initial begin
        int hold;
        hold = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else if (hold == 0 && sink_idling && $urandom_range(0, 3) == 0) begin
                hold = gap_len();
            end
            if (hold != 0) begin
                i_m_axis_tready <= 1'b0;
                hold--;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic test_register_reset();
        cfg_width     = RST_GRID_WIDTH;
        cfg_height    = RST_GRID_HEIGHT;
        cfg_passes    = RST_PASS_COUNT;
        cfg_threshold = RST_WALL_THRESHOLD;
        for (int r = 0; r < 4; r++)
            check_reg(2'(r));
    endtask

    // This grid also fills every entry that any later run or read can touch.
    task automatic test_wide_grid();
        set_config(FILL_WIDTH, MIN_DIM, 1, 5);
        load_random_grid();
        send_item(KIND_RUN, '0, 1'b0, 1'b0);
        send_item(KIND_READ, 12'd0, 1'b0, 1'b0);
        send_item(KIND_READ, 12'(FILL_WIDTH + 1), 1'b0, 1'b0);
        send_item(KIND_READ, 12'(FILL_CELLS - 1), 1'b0, 1'b0);
        wait_idle();
    endtask

    task automatic test_tall_grid();
        set_config(MIN_DIM, FILL_WIDTH, 2, 4);
        send_item(KIND_RUN, '0, 1'b1, 1'b1);
        send_item(KIND_READ, 12'd19, 1'b0, 1'b0);
        // One past the last cell: the load is dropped and the read gives floor.
        send_item(KIND_LOAD, 12'(FILL_CELLS), 1'b1, 1'b1);
        send_item(KIND_READ, 12'(FILL_CELLS), 1'b0, 1'b0);
        wait_idle();
    endtask

    // Sizes out of range are pulled back, so the last cell of a 3 by 64 or 64 by 3 grid is in use.
    task automatic test_size_saturation();
        set_config(0, 127, 1, 5);
        send_item(KIND_LOAD, 12'(SAT_CELLS - 1), 1'b1, 1'b0);
        send_item(KIND_READ, 12'(SAT_CELLS - 1), 1'b0, 1'b0);
        send_item(KIND_LOAD, 12'(SAT_CELLS), 1'b1, 1'b1);
        send_item(KIND_READ, 12'(SAT_CELLS), 1'b0, 1'b0);
        wait_idle();
        set_config(127, 1, 1, 5);
        send_item(KIND_READ, 12'(SAT_CELLS - 1), 1'b0, 1'b0);
        send_item(KIND_READ, 12'(SAT_CELLS), 1'b0, 1'b0);
        wait_idle();
        set_config(2, 0, 1, 5);
        send_item(KIND_RUN, '0, 1'b0, 1'b0);
        wait_idle();
    endtask

    task automatic test_threshold_extremes();
        set_config(4, 4, 1, 0);
        send_item(KIND_RUN, '0, 1'b0, 1'b0);
        wait_idle();
        write_reg(REG_WALL_THRESHOLD, 9);
        send_item(KIND_RUN, '0, 1'b0, 1'b0);
        wait_idle();
        // Above nine no neighbourhood can qualify, so the interior clears.
        write_reg(REG_WALL_THRESHOLD, 15);
        send_item(KIND_RUN, '0, 1'b0, 1'b0);
        wait_idle();
        write_reg(REG_PASS_COUNT, 0);
        send_item(KIND_LOAD, 12'd5, 1'b1, 1'b0);
        send_item(KIND_RUN, '0, 1'b0, 1'b0);
        send_item(KIND_READ, 12'd5, 1'b0, 1'b0);
        wait_idle();
    endtask

    task automatic test_pass_extreme();
        set_config(MIN_DIM, MIN_DIM, 255, 4);
        send_item(KIND_RUN, '0, 1'b0, 1'b0);
        send_item(KIND_READ, 12'd4, 1'b0, 1'b0);
        wait_idle();
    endtask

    task automatic test_odd_items();
        send_item(KIND_LOAD, 12'hFFF, 1'b1, 1'b1);
        send_item(KIND_READ, 12'hFFF, 1'b0, 1'b0);
        send_item(KIND_LOAD, 12'd9, 1'b1, 1'b0);
        send_item(KIND_READ, 12'd9, 1'b0, 1'b0);
        send_item(KIND_UNUSED, 12'hFFF, 1'b1, 1'b1);
        send_item(KIND_UNUSED, 12'd0, 1'b0, 1'b0);
        // A seed wall lands in the scratch copy only, so the map still reads floor.
        send_item(KIND_LOAD, 12'd4, 1'b0, 1'b1);
        send_item(KIND_READ, 12'd4, 1'b0, 1'b0);
        send_item(KIND_READ, 12'd0, 1'b0, 1'b0);
        wait_idle();
    endtask

    // The receiver holds off while beats keep coming, so the input has to stall.
    task automatic test_backpressure();
        set_config(4, 4, 1, 5);
        source_idling = 1'b0;
        long_hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_item(KIND_LOAD, 12'(i), 1'($urandom), 1'($urandom));
        send_item(KIND_RUN, '0, 1'b0, 1'b0);
        send_item(KIND_READ, 12'd6, 1'b0, 1'b0);
        wait_idle();
        source_idling = 1'b1;
    endtask

    task automatic test_random();
        int sent;
        int w;
        int h;
        int n;
        int passes;
        int threshold;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            if ($urandom_range(0, 5) == 0) begin
                w = $urandom_range(9, FILL_WIDTH);
                h = $urandom_range(0, MIN_DIM);
                if ($urandom_range(0, 1) == 0) begin
                    h = w;
                    w = $urandom_range(0, MIN_DIM);
                end
            end else begin
                w = $urandom_range(2, 6);
                h = $urandom_range(2, 6);
            end
            passes = $urandom_range(0, 6);
            if (clamp_dim(w, DEF_MAX_WIDTH) * clamp_dim(h, DEF_MAX_HEIGHT) <= 16
                && $urandom_range(0, 5) == 0)
                passes = 255;
            threshold = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                    : $urandom_range(3, 6);
            set_config(w, h, passes, threshold);
            source_idling = ($urandom_range(0, 3) != 0);
            sink_idling   = ($urandom_range(0, 3) != 0);
            n = used_cells();
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 2) != 0) begin
                    send_item(KIND_LOAD, 12'(i), 1'($urandom), 1'($urandom));
                    sent++;
                end
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 3))
                        0: send_item(KIND_UNUSED, 12'($urandom), 1'($urandom), 1'($urandom));
                        1: send_item(KIND_LOAD, 12'($urandom_range(n, 4095)), 1'($urandom),
                                     1'($urandom));
                        2: send_item(KIND_READ, 12'($urandom_range(n, 4095)), 1'($urandom),
                                     1'($urandom));
                        default: send_item(KIND_READ, 12'($urandom_range(0, n - 1)),
                                           1'($urandom), 1'($urandom));
                    endcase
                    sent++;
                end
            end
            repeat ($urandom_range(1, 2)) begin
                send_item(KIND_RUN, 12'($urandom), 1'($urandom), 1'($urandom));
                sent++;
            end
            repeat ($urandom_range(2, 5)) begin
                send_item(KIND_READ, 12'($urandom_range(0, n - 1)), 1'($urandom),
                          1'($urandom));
                sent++;
            end
        end
        source_idling = 1'b1;
        sink_idling   = 1'b1;
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= KIND_LOAD;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_reset();
        test_wide_grid();
        test_tall_grid();
        test_size_saturation();
        test_threshold_extremes();
        test_pass_extreme();
        test_odd_items();
        test_backpressure();
        test_random();

        wait_idle();
        if (mismatch_count == 0) begin
            $display("[cave_cellular_automaton] OK");
        end else begin
            $display("[cave_cellular_automaton] ERROR");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("[cave_cellular_automaton] ERROR");
        $finish;
    end

endmodule
